FILE: hdl/lsrc_pkg.sv
package lsrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;
    localparam int CODE_W     = 12;
    localparam int RAD_W      = 16;
    localparam int PCT_W      = 7;

    // register indexes past the windows
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd4;

    localparam logic [CFG_DATA_W-1:0] WIN0_RESET   = 33'h1_0258_0898;
    localparam logic [RAD_W-1:0]      THRESH_RESET = 16'd8000;

    localparam logic [CODE_W-1:0] AUTO_ON  = 12'd600;
    localparam logic [CODE_W-1:0] AUTO_OFF = 12'd2200;

    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [5:0] SEC_MAX  = 6'd59;

    localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;
    localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic              usable;
        logic [CODE_W-1:0] on_code;
        logic [CODE_W-1:0] off_code;
    } t_win;

    // HHMM code check; for codes below 2400 the hour is (v * 5243) >> 19
    function automatic logic code_ok(input logic [15:0] v);
        logic [24:0]       prod;
        logic [4:0]        q;
        logic [CODE_W-1:0] r;
        prod = 25'(v[11:0]) * 25'd5243;
        q    = prod[23:19];
        r    = v[11:0] - (12'(q) * 12'd100);
        return (v <= 16'd2359) && (r <= 12'd59);
    endfunction

    // valid HHMM codes order the same way as minutes of the day
    function automatic logic win_hit(input logic [CODE_W-1:0] on_code,
                                     input logic [CODE_W-1:0] off_code,
                                     input logic [CODE_W-1:0] now);
        logic hit;
        if (on_code == off_code) begin
            hit = 1'b1;
        end else if (on_code < off_code) begin
            hit = (now >= on_code) && (now < off_code);
        end else begin
            hit = (now >= on_code) || (now < off_code);
        end
        return hit;
    endfunction

endpackage

FILE: hdl/light_schedule_relay_control_top.sv
// Lamp relay scheduler: each accepted time sample gives one relay result. An item
// is taken every cycle while o_in_ready is high; a result appears once the item
// has moved from the input register into the result register. Each register holds
// one item, so output stalls backpressure the input only when both are full. Window
// times are compared as HHMM codes against hour*100+minute; configuration writes
// take effect once registered in the configuration block.
module light_schedule_relay_control_top #(
    parameter int PERIOD_COUNT = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [4:0]                       i_hour,
    input  logic [5:0]                       i_minute,
    input  logic [5:0]                       i_second,
    input  logic [lsrc_pkg::RAD_W-1:0]       i_radiation_tenths,
    input  logic                             i_autonomous,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_relay_one,
    output logic                             o_relay_two,
    output logic                             o_reduction_active,
    output logic [lsrc_pkg::PCT_W-1:0]       o_light_percent
);
    import lsrc_pkg::*;

    t_win               s_win [PERIOD_COUNT];
    logic [RAD_W-1:0]   s_thresh;
    logic [CODE_W-1:0]  s_now;
    logic               s_active;
    logic               s_time_ok;
    logic               s_out_load;
    logic               s_in_load;

    logic               r_in_vld;
    logic [4:0]         r_hour;
    logic [5:0]         r_minute;
    logic [5:0]         r_second;
    logic [RAD_W-1:0]   r_rad;
    logic               r_auto;

    logic               r_out_vld;
    logic               r_relay_one;
    logic               r_relay_two;
    logic               r_reduction;
    logic [PCT_W-1:0]   r_pct;

    logic               n_relay_one;
    logic               n_relay_two;
    logic               n_reduction;
    logic [PCT_W-1:0]   n_pct;

    lsrc_cfg #(
        .PERIOD_COUNT (PERIOD_COUNT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_win      (s_win),
        .o_thresh   (s_thresh)
    );

    assign s_now = (12'(r_hour) * 12'd100) + 12'(r_minute);

    lsrc_match #(
        .PERIOD_COUNT (PERIOD_COUNT)
    ) u_match (
        .i_now    (s_now),
        .i_auto   (r_auto),
        .i_win    (s_win),
        .o_active (s_active)
    );

    assign s_out_load = !r_out_vld || i_out_ready;
    assign s_in_load  = !r_in_vld || s_out_load;
    assign o_in_ready = s_in_load;

    assign s_time_ok = (r_hour <= HOUR_MAX) && (r_minute <= MIN_MAX)
                       && (r_second <= SEC_MAX);

    always_comb begin
        n_relay_one = 1'b0;
        n_relay_two = 1'b0;
        n_reduction = 1'b0;
        n_pct       = PCT_NONE;
        if (s_time_ok && s_active) begin
            n_relay_one = 1'b1;
            // zero threshold turns reduction off
            if ((s_thresh != '0) && (r_rad >= s_thresh)) begin
                n_reduction = 1'b1;
                n_pct       = PCT_HALF;
            end else begin
                n_relay_two = 1'b1;
                n_pct       = PCT_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_in_load) begin
                r_in_vld <= i_in_valid;
            end
            if (s_out_load) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_load && i_in_valid) begin
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
            r_rad    <= i_radiation_tenths;
            r_auto   <= i_autonomous;
        end
        if (s_out_load && r_in_vld) begin
            r_relay_one <= n_relay_one;
            r_relay_two <= n_relay_two;
            r_reduction <= n_reduction;
            r_pct       <= n_pct;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_relay_one        = r_relay_one;
    assign o_relay_two        = r_relay_two;
    assign o_reduction_active = r_reduction;
    assign o_light_percent    = r_pct;

    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_out_vld) |=> r_out_vld)
        else $error("item in input register did not advance");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld))
        else $error("input stalled with a free register");

    a_relay_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_relay_two || o_relay_one))
        else $error("relay two on without relay one");

    a_reduce_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reduction_active && o_relay_two))
        else $error("reduction with both relays on");

    a_pct_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_light_percent == PCT_FULL && o_relay_two)
                         || (o_light_percent == PCT_HALF && o_relay_one && !o_relay_two)
                         || (o_light_percent == PCT_NONE && !o_relay_one)))
        else $error("light percent disagrees with relays");

endmodule

FILE: hdl/lsrc_cfg.sv
module lsrc_cfg #(
    parameter int PERIOD_COUNT = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lsrc_pkg::t_win                   o_win [PERIOD_COUNT],
    output logic [lsrc_pkg::RAD_W-1:0]       o_thresh
);
    import lsrc_pkg::*;

    logic [CFG_DATA_W-1:0] r_win [PERIOD_COUNT];
    logic [RAD_W-1:0]      r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PERIOD_COUNT; k++) begin
                r_win[k] <= (k == 0) ? WIN0_RESET : '0;
            end
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            for (int k = 0; k < PERIOD_COUNT; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_win[k] <= i_cfg_data;
                end
            end
            if (i_cfg_idx == CFG_THRESH) begin
                r_thresh <= i_cfg_data[RAD_W-1:0];
            end
        end
    end

    // a window is usable only when enabled and both codes are real times
    always_comb begin
        for (int k = 0; k < PERIOD_COUNT; k++) begin
            o_win[k].usable   = r_win[k][32] && code_ok(r_win[k][31:16])
                                && code_ok(r_win[k][15:0]);
            o_win[k].on_code  = r_win[k][27:16];
            o_win[k].off_code = r_win[k][11:0];
        end
    end

    assign o_thresh = r_thresh;

endmodule

FILE: hdl/lsrc_match.sv
module lsrc_match #(
    parameter int PERIOD_COUNT = 4
) (
    input  logic [lsrc_pkg::CODE_W-1:0] i_now,
    input  logic                        i_auto,
    input  lsrc_pkg::t_win              i_win [PERIOD_COUNT],
    output logic                        o_active
);
    import lsrc_pkg::*;

    logic [PERIOD_COUNT-1:0] s_hit;

    always_comb begin
        for (int k = 0; k < PERIOD_COUNT; k++) begin
            s_hit[k] = i_win[k].usable
                       && win_hit(i_win[k].on_code, i_win[k].off_code, i_now);
        end
    end

    assign o_active = i_auto ? win_hit(AUTO_ON, AUTO_OFF, i_now) : (|s_hit);

endmodule
